@@ hdl/ebb_pkg.sv @@
// ----------------------------------------------------------------------------
// ebb_pkg
// Widths, constants and shared helpers for the ellipsoid bounding box pipeline
// ----------------------------------------------------------------------------
package ebb_pkg;

    // cordic iterations, one pipeline stage each (8 to 24)
    localparam int CORDIC_STAGES = 16;

    localparam int AXIS_W   = 24;
    localparam int ANGLE_W  = 16;
    localparam int WIDTH_W  = 17;
    localparam int TRIG_W   = 32;
    localparam int CORDIC_W = 34;
    localparam int COEF_W   = 33;
    localparam int MPROD_W  = AXIS_W + 1 + COEF_W;
    localparam int MAT_W    = 31;
    localparam int SQR_W    = 2 * MAT_W;
    localparam int SUM_W    = 64;
    localparam int ROOT_BITS = 32;
    localparam int RED_W    = 17;
    localparam int RAD_W    = 20;

    // pipeline bookkeeping
    localparam int PIPE_DEPTH = CORDIC_STAGES + ROOT_BITS + 10;
    localparam int AXIS_DEPTH = CORDIC_STAGES + 6;

    // angle units, Q10.6 degrees
    localparam logic signed [RED_W-1:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [RED_W-1:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [RED_W-1:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [RAD_W-1:0] RAD_SCALE    = 20'sd292818;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [AXIS_W-1:0] EXTENT_MAX = 24'hFFFFFF;

    // arctangent of 2^-i in Q2.30, truncated
    localparam logic [31:0] ATAN_Q30 [0:23] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_val;
        logic signed [TRIG_W-1:0] cos_val;
    } trig_t;

    // Q2.30 product, rounded half up
    function automatic logic signed [TRIG_W-1:0] qmul(
        input logic signed [TRIG_W-1:0] p,
        input logic signed [TRIG_W-1:0] q
    );
        logic signed [2*TRIG_W-1:0] prod;
        prod = p * q;
        prod = prod + (64'sd1 <<< 29);
        return prod[TRIG_W+29:30];
    endfunction

endpackage

@@ hdl/ebb_cordic.sv @@
// ----------------------------------------------------------------------------
// ebb_cordic
// Pipelined sine and cosine of a Q10.6 degree angle, one iteration per stage
// ----------------------------------------------------------------------------
module ebb_cordic (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [ebb_pkg::ANGLE_W-1:0] angle,
    output ebb_pkg::trig_t                    trig
);
    import ebb_pkg::*;

    logic signed [RED_W-1:0]     ang_ext;
    logic signed [RED_W-1:0]     red;
    logic signed [RED_W-1:0]     fold;
    logic                        flip_next;
    logic signed [RED_W+RAD_W-1:0] z_full;

    logic signed [CORDIC_W-1:0]  x_reg [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  y_reg [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  z_reg [0:CORDIC_STAGES];
    logic                        flip_reg [0:CORDIC_STAGES];

    logic signed [CORDIC_W-1:0]  sin_next;
    logic signed [CORDIC_W-1:0]  cos_next;
    trig_t                       trig_reg;

    // reduce to (-180,180], then fold into +-90 degrees
    always_comb begin
        ang_ext = RED_W'(angle);
        if (ang_ext > HALF_TURN) begin
            red = ang_ext - FULL_TURN;
        end else if (ang_ext <= -HALF_TURN) begin
            red = ang_ext + FULL_TURN;
        end else begin
            red = ang_ext;
        end
        flip_next = 1'b0;
        fold      = red;
        if (red > QUARTER_TURN) begin
            fold      = red - HALF_TURN;
            flip_next = 1'b1;
        end else if (red < -QUARTER_TURN) begin
            fold      = red + HALF_TURN;
            flip_next = 1'b1;
        end
        z_full = fold * RAD_SCALE;
    end

    // seed stage: radians in Q2.30
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= CORDIC_W'(z_full);
            flip_reg[0] <= flip_next;
        end
    end

    // rotation stages
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [CORDIC_W-1:0] at;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        assign at = $signed({2'b00, ATAN_Q30[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][CORDIC_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // undo the half-turn fold
    always_comb begin
        sin_next = flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        cos_next = flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg.sin_val <= sin_next[TRIG_W-1:0];
            trig_reg.cos_val <= cos_next[TRIG_W-1:0];
        end
    end

    assign trig = trig_reg;

endmodule

@@ hdl/ellipsoid_bounding_box.sv @@
// throughput: one beat per cycle while the result side does not stall, set by the
// fully pipelined cordic and root stages
// a stall on the result side holds the whole pipeline, nothing is dropped
// reset (aresetn low, synchronous) clears the valid bits only
// ----------------------------------------------------------------------------
// ellipsoid_bounding_box
// Axis-aligned half extents and odd box widths of a rotated ellipsoid
// ----------------------------------------------------------------------------
module ellipsoid_bounding_box (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ebb_pkg::AXIS_W-1:0]          s_semi_axis_a,
    input  logic [ebb_pkg::AXIS_W-1:0]          s_semi_axis_b,
    input  logic [ebb_pkg::AXIS_W-1:0]          s_semi_axis_c,
    input  logic signed [ebb_pkg::ANGLE_W-1:0]  s_angle_first,
    input  logic signed [ebb_pkg::ANGLE_W-1:0]  s_angle_second,
    input  logic signed [ebb_pkg::ANGLE_W-1:0]  s_angle_third,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ebb_pkg::AXIS_W-1:0]          m_extent_x,
    output logic [ebb_pkg::AXIS_W-1:0]          m_extent_y,
    output logic [ebb_pkg::AXIS_W-1:0]          m_extent_z,
    output logic [ebb_pkg::WIDTH_W-1:0]         m_width_x,
    output logic [ebb_pkg::WIDTH_W-1:0]         m_width_y,
    output logic [ebb_pkg::WIDTH_W-1:0]         m_width_z,
    output logic                               m_axis_error
);
    import ebb_pkg::*;

    logic adv;

    logic vld_reg [0:PIPE_DEPTH-1];
    logic err_reg [0:PIPE_DEPTH-1];
    logic [AXIS_W-1:0] ax_reg [0:AXIS_DEPTH-1][0:2];
    logic signed [ANGLE_W-1:0] ang_reg [0:2];

    trig_t t1, t2, t3;

    logic signed [TRIG_W-1:0] s1c2_reg, c1c2_reg, c1c3_reg, c1s3_reg, s1s2_reg;
    logic signed [TRIG_W-1:0] s1c3_reg, s1s3_reg, c1s2_reg, s2s3_reg, s2c3_reg;
    logic signed [TRIG_W-1:0] s3_reg, c3_reg, c2_reg;

    logic signed [TRIG_W-1:0] s1c2s3_reg, s1c2c3_reg, c1c2s3_reg, c1c2c3_reg;
    logic signed [TRIG_W-1:0] c1c3_p2_reg, c1s3_p2_reg, s1s2_p2_reg, s1c3_p2_reg;
    logic signed [TRIG_W-1:0] s1s3_p2_reg, c1s2_p2_reg, s2s3_p2_reg, s2c3_p2_reg;
    logic signed [TRIG_W-1:0] c2_p2_reg;

    logic signed [COEF_W-1:0]  coef_reg [0:8];
    logic signed [MPROD_W-1:0] mprod [0:8];
    logic signed [MAT_W-1:0]   m_reg [0:8];
    logic [MAT_W-1:0]          mabs [0:8];
    logic [SQR_W-1:0]          sq_reg [0:8];

    logic [SUM_W-1:0]      rem_reg [0:ROOT_BITS][0:2];
    logic [ROOT_BITS-1:0]  q_reg   [0:ROOT_BITS][0:2];

    logic [ROOT_BITS-5:0]  ext_full [0:2];
    logic [AXIS_W-1:0]     ext_sat  [0:2];
    logic [AXIS_W-1:0]     ext_reg  [0:2];
    logic [WIDTH_W-1:0]    wid_reg  [0:2];

    // whole pipeline advances unless the result beat is held
    assign adv     = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // input capture, error flag and axis delay line
    always_ff @(posedge aclk) begin
        if (adv) begin
            err_reg[0]   <= (s_semi_axis_b > s_semi_axis_a) || (s_semi_axis_c > s_semi_axis_a);
            ax_reg[0][0] <= s_semi_axis_a;
            ax_reg[0][1] <= s_semi_axis_b;
            ax_reg[0][2] <= s_semi_axis_c;
            ang_reg[0]   <= s_angle_first;
            ang_reg[1]   <= s_angle_second;
            ang_reg[2]   <= s_angle_third;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                err_reg[k] <= err_reg[k-1];
            end
            for (int k = 1; k < AXIS_DEPTH; k++) begin
                for (int j = 0; j < 3; j++) begin
                    ax_reg[k][j] <= ax_reg[k-1][j];
                end
            end
        end
    end

    // sine and cosine of the three angles
    ebb_cordic u_cordic_first (
        .aclk  (aclk),
        .en    (adv),
        .angle (ang_reg[0]),
        .trig  (t1)
    );

    ebb_cordic u_cordic_second (
        .aclk  (aclk),
        .en    (adv),
        .angle (ang_reg[1]),
        .trig  (t2)
    );

    ebb_cordic u_cordic_third (
        .aclk  (aclk),
        .en    (adv),
        .angle (ang_reg[2]),
        .trig  (t3)
    );

    // first trig products
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1c2_reg <= qmul(t1.sin_val, t2.cos_val);
            c1c2_reg <= qmul(t1.cos_val, t2.cos_val);
            c1c3_reg <= qmul(t1.cos_val, t3.cos_val);
            c1s3_reg <= qmul(t1.cos_val, t3.sin_val);
            s1s2_reg <= qmul(t1.sin_val, t2.sin_val);
            s1c3_reg <= qmul(t1.sin_val, t3.cos_val);
            s1s3_reg <= qmul(t1.sin_val, t3.sin_val);
            c1s2_reg <= qmul(t1.cos_val, t2.sin_val);
            s2s3_reg <= qmul(t2.sin_val, t3.sin_val);
            s2c3_reg <= qmul(t2.sin_val, t3.cos_val);
            s3_reg   <= t3.sin_val;
            c3_reg   <= t3.cos_val;
            c2_reg   <= t2.cos_val;
        end
    end

    // triple products
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1c2s3_reg  <= qmul(s1c2_reg, s3_reg);
            s1c2c3_reg  <= qmul(s1c2_reg, c3_reg);
            c1c2s3_reg  <= qmul(c1c2_reg, s3_reg);
            c1c2c3_reg  <= qmul(c1c2_reg, c3_reg);
            c1c3_p2_reg <= c1c3_reg;
            c1s3_p2_reg <= c1s3_reg;
            s1s2_p2_reg <= s1s2_reg;
            s1c3_p2_reg <= s1c3_reg;
            s1s3_p2_reg <= s1s3_reg;
            c1s2_p2_reg <= c1s2_reg;
            s2s3_p2_reg <= s2s3_reg;
            s2c3_p2_reg <= s2c3_reg;
            c2_p2_reg   <= c2_reg;
        end
    end

    // rotation matrix coefficients
    always_ff @(posedge aclk) begin
        if (adv) begin
            coef_reg[0] <= COEF_W'(c1c3_p2_reg) - COEF_W'(s1c2s3_reg);
            coef_reg[1] <= -(COEF_W'(c1s3_p2_reg) + COEF_W'(s1c2c3_reg));
            coef_reg[2] <= COEF_W'(s1s2_p2_reg);
            coef_reg[3] <= COEF_W'(s1c3_p2_reg) + COEF_W'(c1c2s3_reg);
            coef_reg[4] <= COEF_W'(c1c2c3_reg) - COEF_W'(s1s3_p2_reg);
            coef_reg[5] <= -COEF_W'(c1s2_p2_reg);
            coef_reg[6] <= COEF_W'(s2s3_p2_reg);
            coef_reg[7] <= COEF_W'(s2c3_p2_reg);
            coef_reg[8] <= COEF_W'(c2_p2_reg);
        end
    end

    // scale each coefficient by its column's semi-axis, Q12 result
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mprod[r*3+c] = $signed({1'b0, ax_reg[AXIS_DEPTH-1][c]}) * coef_reg[r*3+c];
                mprod[r*3+c] = mprod[r*3+c] + (58'sd1 <<< 25);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                m_reg[k] <= mprod[k][MAT_W+25:26];
            end
        end
    end

    // squares of the matrix entries
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            mabs[k] = m_reg[k][MAT_W-1] ? MAT_W'(-m_reg[k]) : MAT_W'(m_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                sq_reg[k] <= mabs[k] * mabs[k];
            end
        end
    end

    // row sums seed the root stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                rem_reg[0][r] <= SUM_W'(sq_reg[r*3]) + SUM_W'(sq_reg[r*3+1])
                               + SUM_W'(sq_reg[r*3+2]);
                q_reg[0][r]   <= '0;
            end
        end
    end

    // restoring square root, one root bit per stage
    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
        localparam int K = ROOT_BITS - 1 - j;
        for (genvar r = 0; r < 3; r++) begin : g_row
            logic [SUM_W+1:0] trial;
            assign trial = ((SUM_W+2)'(q_reg[j][r]) << (K + 1))
                         + ((SUM_W+2)'(1) << (2 * K));
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if ({2'b00, rem_reg[j][r]} >= trial) begin
                        rem_reg[j+1][r] <= rem_reg[j][r] - trial[SUM_W-1:0];
                        q_reg[j+1][r]   <= q_reg[j][r] | (ROOT_BITS'(1) << K);
                    end else begin
                        rem_reg[j+1][r] <= rem_reg[j][r];
                        q_reg[j+1][r]   <= q_reg[j][r];
                    end
                end
            end
        end
    end

    // extent in Q16.8 with saturation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            ext_full[r] = q_reg[ROOT_BITS][r][ROOT_BITS-1:4];
            if (ext_full[r] > (ROOT_BITS-4)'(EXTENT_MAX)) begin
                ext_sat[r] = EXTENT_MAX;
            end else begin
                ext_sat[r] = ext_full[r][AXIS_W-1:0];
            end
        end
    end

    // result register, zeroed on an axis order error
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                if (err_reg[PIPE_DEPTH-2]) begin
                    ext_reg[r] <= '0;
                    wid_reg[r] <= '0;
                end else begin
                    ext_reg[r] <= ext_sat[r];
                    wid_reg[r] <= {ext_sat[r][AXIS_W-1:8], 1'b1};
                end
            end
        end
    end

    assign m_valid      = vld_reg[PIPE_DEPTH-1];
    assign m_extent_x   = ext_reg[0];
    assign m_extent_y   = ext_reg[1];
    assign m_extent_z   = ext_reg[2];
    assign m_width_x    = wid_reg[0];
    assign m_width_y    = wid_reg[1];
    assign m_width_z    = wid_reg[2];
    assign m_axis_error = err_reg[PIPE_DEPTH-1];

endmodule

@@ dv/ebb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebb_checker
// Watches both channels of the bounding box block, computes the expected
// extents and widths for every accepted input beat and compares result beats
// in order
// ----------------------------------------------------------------------------
module ebb_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [ebb_pkg::AXIS_W-1:0]          s_semi_axis_a,
    input  logic [ebb_pkg::AXIS_W-1:0]          s_semi_axis_b,
    input  logic [ebb_pkg::AXIS_W-1:0]          s_semi_axis_c,
    input  logic signed [ebb_pkg::ANGLE_W-1:0]  s_angle_first,
    input  logic signed [ebb_pkg::ANGLE_W-1:0]  s_angle_second,
    input  logic signed [ebb_pkg::ANGLE_W-1:0]  s_angle_third,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [ebb_pkg::AXIS_W-1:0]          m_extent_x,
    input  logic [ebb_pkg::AXIS_W-1:0]          m_extent_y,
    input  logic [ebb_pkg::AXIS_W-1:0]          m_extent_z,
    input  logic [ebb_pkg::WIDTH_W-1:0]         m_width_x,
    input  logic [ebb_pkg::WIDTH_W-1:0]         m_width_y,
    input  logic [ebb_pkg::WIDTH_W-1:0]         m_width_z,
    input  logic                               m_axis_error,
    output int                                 fail_count,
    output int                                 box_pending
);
    import ebb_pkg::*;

    typedef struct {
        logic [AXIS_W-1:0]  ext [3];
        logic [WIDTH_W-1:0] wid [3];
        logic               err;
    } box_t;

    box_t box_queue[$];

    function automatic longint shift_down(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint trig_mul(longint p, longint q);
        return shift_down(p * q + (64'sd1 <<< 29), 30);
    endfunction

    // quadrant reduction then rotation-mode cordic
    function automatic void angle_trig(input logic signed [ANGLE_W-1:0] ang,
                                       output longint sv, output longint cv);
        int     r;
        bit     flip;
        longint x, y, z, dx, dy;
        r = int'(ang) % 23040;
        if (r < 0) r += 23040;
        if (r > 11520) r -= 23040;
        flip = 0;
        if (r > 5760) begin
            r -= 11520;
            flip = 1;
        end else if (r < -5760) begin
            r += 11520;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = longint'(r) * 292818;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = shift_down(y, i);
            dy = shift_down(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_Q30[i]);
            end
        end
        sv = flip ? -y : y;
        cv = flip ? -x : x;
    endfunction

    function automatic longint unsigned entry_sq(longint ax, longint cf);
        longint m;
        m = shift_down(ax * cf + (64'sd1 <<< 25), 26);
        if (m < 0) m = -m;
        return longint'(m) * longint'(m);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic box_t predict_box(logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b,
                                         logic [AXIS_W-1:0] c, logic signed [ANGLE_W-1:0] t1,
                                         logic signed [ANGLE_W-1:0] t2,
                                         logic signed [ANGLE_W-1:0] t3);
        box_t            bx;
        longint          s1, c1, s2, c2, s3, c3, s1c2, c1c2;
        longint          cf [9];
        longint          ax [3];
        longint unsigned sum, ext;
        if (b > a || c > a) begin
            for (int i = 0; i < 3; i++) begin
                bx.ext[i] = '0;
                bx.wid[i] = '0;
            end
            bx.err = 1'b1;
            return bx;
        end
        angle_trig(t1, s1, c1);
        angle_trig(t2, s2, c2);
        angle_trig(t3, s3, c3);
        s1c2 = trig_mul(s1, c2);
        c1c2 = trig_mul(c1, c2);
        cf[0] = trig_mul(c1, c3) - trig_mul(s1c2, s3);
        cf[1] = -(trig_mul(c1, s3) + trig_mul(s1c2, c3));
        cf[2] = trig_mul(s1, s2);
        cf[3] = trig_mul(s1, c3) + trig_mul(c1c2, s3);
        cf[4] = trig_mul(c1c2, c3) - trig_mul(s1, s3);
        cf[5] = -trig_mul(c1, s2);
        cf[6] = trig_mul(s2, s3);
        cf[7] = trig_mul(s2, c3);
        cf[8] = c2;
        ax[0] = a;
        ax[1] = b;
        ax[2] = c;
        for (int i = 0; i < 3; i++) begin
            sum = entry_sq(ax[0], cf[i*3]) + entry_sq(ax[1], cf[i*3+1])
                + entry_sq(ax[2], cf[i*3+2]);
            ext = int_root(sum) >> 4;
            if (ext > 64'hFFFFFF) ext = 64'hFFFFFF;
            bx.ext[i] = ext[AXIS_W-1:0];
            bx.wid[i] = WIDTH_W'(2 * (ext >> 8) + 1);
        end
        bx.err = 1'b0;
        return bx;
    endfunction

    // predict on input beats, compare on result beats
    always @(posedge aclk) begin
        box_t exp_box;
        box_t got;
        if (!aresetn) begin
            box_queue.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready)
                box_queue.push_back(predict_box(s_semi_axis_a, s_semi_axis_b, s_semi_axis_c,
                                                s_angle_first, s_angle_second,
                                                s_angle_third));
            if (m_valid && m_ready) begin
                got.ext[0] = m_extent_x;
                got.ext[1] = m_extent_y;
                got.ext[2] = m_extent_z;
                got.wid[0] = m_width_x;
                got.wid[1] = m_width_y;
                got.wid[2] = m_width_z;
                got.err    = m_axis_error;
                if (box_queue.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_count++;
                end else begin
                    exp_box = box_queue.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.ext[i] !== exp_box.ext[i]) begin
                            $display("%0t: extent[%0d] expected %0d actual %0d", $time, i,
                                     exp_box.ext[i], got.ext[i]);
                            fail_count++;
                        end
                        if (got.wid[i] !== exp_box.wid[i]) begin
                            $display("%0t: width[%0d] expected %0d actual %0d", $time, i,
                                     exp_box.wid[i], got.wid[i]);
                            fail_count++;
                        end
                    end
                    if (got.err !== exp_box.err) begin
                        $display("%0t: axis_error expected %0b actual %0b", $time,
                                 exp_box.err, got.err);
                        fail_count++;
                    end
                end
            end
        end
        box_pending = box_queue.size();
    end
endmodule

@@ dv/tb_ellipsoid_bounding_box.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ellipsoid_bounding_box
// Drives directed and random ellipsoids into the bounding box block with
// random gaps and result-side stalls; the checker judges every result beat
// ----------------------------------------------------------------------------
module tb_ellipsoid_bounding_box;
    import ebb_pkg::*;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [AXIS_W-1:0]          s_semi_axis_a;
    logic [AXIS_W-1:0]          s_semi_axis_b;
    logic [AXIS_W-1:0]          s_semi_axis_c;
    logic signed [ANGLE_W-1:0]  s_angle_first;
    logic signed [ANGLE_W-1:0]  s_angle_second;
    logic signed [ANGLE_W-1:0]  s_angle_third;
    logic                       m_valid;
    logic                       m_ready;
    logic [AXIS_W-1:0]          m_extent_x;
    logic [AXIS_W-1:0]          m_extent_y;
    logic [AXIS_W-1:0]          m_extent_z;
    logic [WIDTH_W-1:0]         m_width_x;
    logic [WIDTH_W-1:0]         m_width_y;
    logic [WIDTH_W-1:0]         m_width_z;
    logic                       m_axis_error;
    int                         fail_count;
    int                         box_pending;
    bit                         calm_phase;

    ellipsoid_bounding_box u_top (.*);

    ebb_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side stalls, none during the calm phase
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= calm_phase || ($urandom_range(99) >= 22);
        end
    end

    task automatic send_box(logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b,
                            logic [AXIS_W-1:0] c, logic signed [ANGLE_W-1:0] t1,
                            logic signed [ANGLE_W-1:0] t2, logic signed [ANGLE_W-1:0] t3);
        if (!calm_phase) begin
            while ($urandom_range(99) < 22) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_semi_axis_a  <= a;
        s_semi_axis_b  <= b;
        s_semi_axis_c  <= c;
        s_angle_first  <= t1;
        s_angle_second <= t2;
        s_angle_third  <= t3;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(3))
            0:       return ANGLE_W'($urandom);
            1:       return ANGLE_W'(int'($urandom_range(46080)) - 23040);
            default: return ANGLE_W'(int'($urandom_range(640)) * 36 - 11520);
        endcase
    endfunction

    function automatic logic [AXIS_W-1:0] rand_axis();
        case ($urandom_range(3))
            0:       return AXIS_W'($urandom);
            1:       return AXIS_W'($urandom_range(65535));
            default: return AXIS_W'($urandom_range(4095));
        endcase
    endfunction

    initial begin
        logic [AXIS_W-1:0] a, b, c;
        aresetn        = 1'b0;
        calm_phase     = 1'b0;
        s_valid        = 1'b0;
        s_semi_axis_a  = '0;
        s_semi_axis_b  = '0;
        s_semi_axis_c  = '0;
        s_angle_first  = '0;
        s_angle_second = '0;
        s_angle_third  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zeros, largest axes, angle extremes, quadrant edges, axis order error
        send_box(0, 0, 0, 0, 0, 0);
        send_box(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0);
        send_box(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 2880, 2880, 2880);
        send_box(24'hFFFFFF, 24'h800000, 24'h000001, 16'sh7FFF, -16'sh8000, 5760);
        send_box(24'h000A00, 24'h000500, 24'h000100, 23040, -23040, 11520);
        send_box(24'h000A00, 24'h000500, 24'h000100, -11520, 5760, -5760);
        send_box(24'h000A00, 24'h000500, 24'h000100, 5761, -5761, 11519);
        send_box(24'h001000, 24'h000800, 24'h000400, 1920, 2880, 960);
        send_box(24'h000100, 24'h000200, 24'h000000, 0, 0, 0);
        send_box(24'h000100, 24'h000000, 24'h000200, 0, 0, 0);
        send_box(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 100, 200, 300);
        send_box(24'hFFFFFF, 24'h555555, 24'hAAAAAA, 16'sh5555, 16'shAAAA, -1);

        // random: mostly well-ordered axes, a share of order errors
        for (int n = 0; n < 540; n++) begin
            calm_phase = (n >= 200 && n < 280);
            a = rand_axis();
            b = rand_axis();
            c = rand_axis();
            if ($urandom_range(99) < 85) begin
                if (b > a) {a, b} = {b, a};
                if (c > a) {a, c} = {c, a};
            end
            send_box(a, b, c, rand_angle(), rand_angle(), rand_angle());
        end
        s_valid    <= 1'b0;
        calm_phase = 1'b0;

        while (box_pending != 0) @(posedge aclk);
        repeat (CORDIC_STAGES + 60) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end
endmodule
